// ----- rtl/core/lts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lts_pkg;

	// Default width of the internal skip and length counters.
	localparam int COUNT_BITS_DEF = 16;

	// Widths of the beat fields.
	localparam int CHAR_BITS = 21;
	localparam int MASK_BITS = 3;
	localparam int OUT_COUNT_BITS = 16;

	// Characters that steer the scan.
	localparam logic [CHAR_BITS-1:0] CH_QUOTE = CHAR_BITS'(34);
	localparam logic [CHAR_BITS-1:0] CH_BSLASH = CHAR_BITS'(92);
	localparam logic [CHAR_BITS-1:0] CH_HASH = CHAR_BITS'(35);
	localparam logic [CHAR_BITS-1:0] CH_SEMI = CHAR_BITS'(59);
	localparam logic [CHAR_BITS-1:0] CH_NEWLINE = CHAR_BITS'(10);
	localparam logic [CHAR_BITS-1:0] CH_SPACE = CHAR_BITS'(32);
	localparam logic [CHAR_BITS-1:0] CH_TAB = CHAR_BITS'(9);
	localparam logic [CHAR_BITS-1:0] CH_CR = CHAR_BITS'(13);
	localparam logic [CHAR_BITS-1:0] CH_PLUS = CHAR_BITS'(43);
	localparam logic [CHAR_BITS-1:0] CH_MINUS = CHAR_BITS'(45);
	localparam logic [CHAR_BITS-1:0] CH_0 = CHAR_BITS'(48);
	localparam logic [CHAR_BITS-1:0] CH_9 = CHAR_BITS'(57);
	localparam logic [CHAR_BITS-1:0] CH_UA = CHAR_BITS'(65);
	localparam logic [CHAR_BITS-1:0] CH_UZ = CHAR_BITS'(90);
	localparam logic [CHAR_BITS-1:0] CH_LA = CHAR_BITS'(97);
	localparam logic [CHAR_BITS-1:0] CH_LZ = CHAR_BITS'(122);
	localparam logic [CHAR_BITS-1:0] CH_UB = CHAR_BITS'(66);
	localparam logic [CHAR_BITS-1:0] CH_LB = CHAR_BITS'(98);
	localparam logic [CHAR_BITS-1:0] CH_UO = CHAR_BITS'(79);
	localparam logic [CHAR_BITS-1:0] CH_LO = CHAR_BITS'(111);
	localparam logic [CHAR_BITS-1:0] CH_UX = CHAR_BITS'(88);
	localparam logic [CHAR_BITS-1:0] CH_LX = CHAR_BITS'(120);
	localparam logic [CHAR_BITS-1:0] CH_UR = CHAR_BITS'(82);
	localparam logic [CHAR_BITS-1:0] CH_LR = CHAR_BITS'(114);

	// Radix limits.
	localparam logic [6:0] RADIX_MIN = 7'd2;
	localparam logic [6:0] RADIX_MAX = 7'd36;
	localparam logic [6:0] RADIX_BIN = 7'd2;
	localparam logic [6:0] RADIX_OCT = 7'd8;
	localparam logic [6:0] RADIX_HEX = 7'd16;

	// Allowed-kind mask bits.
	localparam int MASK_STRING = 0;
	localparam int MASK_RADIX = 1;
	localparam int MASK_COMMENT = 2;

	// Reported token kinds.
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_STRING = 2'd1,
		KIND_RADIX = 2'd2,
		KIND_COMMENT = 2'd3
	} kind_t;

	// One input beat.
	typedef struct packed {
		logic start;
		logic [MASK_BITS-1:0] mask;
		logic [CHAR_BITS-1:0] ch;
		logic eof;
	} item_t;

	// One result beat.
	typedef struct packed {
		kind_t kind;
		logic [OUT_COUNT_BITS-1:0] skipped;
		logic [OUT_COUNT_BITS-1:0] length;
		logic took;
	} res_t;

	// Value of an alphanumeric digit.
	typedef struct packed {
		logic hit;
		logic [5:0] val;
	} digit_t;

	function automatic digit_t digit_of(input logic [CHAR_BITS-1:0] c);
		digit_t d;
		d.hit = 1'b0;
		d.val = 6'd0;
		if (c >= CH_0 && c <= CH_9) begin
			d.hit = 1'b1;
			d.val = 6'(c - CH_0);
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d.hit = 1'b1;
			d.val = 6'(c - CH_UA + CHAR_BITS'(10));
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d.hit = 1'b1;
			d.val = 6'(c - CH_LA + CHAR_BITS'(10));
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lts_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lts_in_stage (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire lts_pkg::item_t item,
	input wire logic advance,
	output logic valid_s1,
	output lts_pkg::item_t item_s1
);

	// A new beat may enter when the register is empty or drains this cycle.
	assign in_ready = !valid_s1 || advance;

	// Occupancy of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload, loaded on every accepted beat.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/lts_scan_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lts_scan_core #(
	parameter int COUNT_BITS = lts_pkg::COUNT_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step_en,
	input wire lts_pkg::item_t item,
	output logic emit,
	output lts_pkg::res_t res
);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_WS,
		PH_STR,
		PH_ESC,
		PH_HASH,
		PH_RDIG,
		PH_SIGN,
		PH_DIGITS,
		PH_CMT
	} phase_t;

	typedef logic [COUNT_BITS-1:0] cnt_t;

	phase_t ph_q, ph_c, ph_nx;
	logic [lts_pkg::MASK_BITS-1:0] mask_q, mask_c;
	logic [6:0] rad_q, rad_c, rad_nx;
	logic [1:0] rcnt_q, rcnt_c, rcnt_nx;
	logic seen_q, seen_c, seen_nx;
	logic dvalid_q, dvalid_c, dvalid_nx;
	cnt_t skip_q, skip_c, skip_nx;
	cnt_t len_q, len_c, len_nx;
	logic [9:0] rad_mul;
	logic is_ws;
	logic is_dec;
	logic do_digits;
	lts_pkg::digit_t dig;
	lts_pkg::kind_t kind_o;
	logic took_o;
	logic [lts_pkg::OUT_COUNT_BITS-1:0] skip16;
	logic [lts_pkg::OUT_COUNT_BITS-1:0] len16;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// Character classes of the current beat.
	assign is_ws = (item.ch == lts_pkg::CH_SPACE) ||
		(item.ch >= lts_pkg::CH_TAB && item.ch <= lts_pkg::CH_CR);
	assign is_dec = (item.ch >= lts_pkg::CH_0) && (item.ch <= lts_pkg::CH_9);
	assign dig = lts_pkg::digit_of(item.ch);
	assign rad_mul = {rad_c, 3'b000} + {2'b00, rad_c, 1'b0} + {6'd0, item.ch[3:0]};

	// A start beat opens a fresh scan from cleared state.
	always_comb begin
		if (item.start) begin
			ph_c = PH_WS;
			mask_c = item.mask;
			rad_c = 7'd0;
			rcnt_c = 2'd0;
			seen_c = 1'b0;
			dvalid_c = 1'b1;
			skip_c = '0;
			len_c = '0;
		end else begin
			ph_c = ph_q;
			mask_c = mask_q;
			rad_c = rad_q;
			rcnt_c = rcnt_q;
			seen_c = seen_q;
			dvalid_c = dvalid_q;
			skip_c = skip_q;
			len_c = len_q;
		end
	end

	// Scan step for one character.
	always_comb begin
		ph_nx = ph_c;
		rad_nx = rad_c;
		rcnt_nx = rcnt_c;
		seen_nx = seen_c;
		dvalid_nx = dvalid_c;
		skip_nx = skip_c;
		len_nx = len_c;
		emit = 1'b0;
		kind_o = lts_pkg::KIND_NONE;
		took_o = 1'b0;
		do_digits = 1'b0;
		if (item.start && item.mask == '0) begin
			emit = 1'b1;
			ph_nx = PH_IDLE;
		end else begin
			case (ph_c)
				PH_WS: begin
					if (!item.eof && is_ws) begin
						skip_nx = sat_inc(skip_c);
					end else if (!item.eof && mask_c[lts_pkg::MASK_STRING] &&
							item.ch == lts_pkg::CH_QUOTE) begin
						len_nx = sat_inc(len_c);
						ph_nx = PH_STR;
					end else if (!item.eof && mask_c[lts_pkg::MASK_RADIX] &&
							item.ch == lts_pkg::CH_HASH) begin
						len_nx = sat_inc(len_c);
						ph_nx = PH_HASH;
					end else if (!item.eof && mask_c[lts_pkg::MASK_COMMENT] &&
							item.ch == lts_pkg::CH_SEMI) begin
						len_nx = sat_inc(len_c);
						ph_nx = PH_CMT;
					end else begin
						emit = 1'b1;
						ph_nx = PH_IDLE;
					end
				end
				PH_STR: begin
					if (item.eof) begin
						emit = 1'b1;
						ph_nx = PH_IDLE;
					end else begin
						len_nx = sat_inc(len_c);
						if (item.ch == lts_pkg::CH_QUOTE) begin
							emit = 1'b1;
							kind_o = lts_pkg::KIND_STRING;
							took_o = 1'b1;
							ph_nx = PH_IDLE;
						end else if (item.ch == lts_pkg::CH_BSLASH) begin
							ph_nx = PH_ESC;
						end
					end
				end
				PH_ESC: begin
					if (item.eof) begin
						emit = 1'b1;
						ph_nx = PH_IDLE;
					end else begin
						len_nx = sat_inc(len_c);
						ph_nx = PH_STR;
					end
				end
				PH_HASH: begin
					if (item.eof) begin
						emit = 1'b1;
						ph_nx = PH_IDLE;
					end else if (item.ch == lts_pkg::CH_LB || item.ch == lts_pkg::CH_UB) begin
						rad_nx = lts_pkg::RADIX_BIN;
						len_nx = sat_inc(len_c);
						ph_nx = PH_SIGN;
					end else if (item.ch == lts_pkg::CH_LO || item.ch == lts_pkg::CH_UO) begin
						rad_nx = lts_pkg::RADIX_OCT;
						len_nx = sat_inc(len_c);
						ph_nx = PH_SIGN;
					end else if (item.ch == lts_pkg::CH_LX || item.ch == lts_pkg::CH_UX) begin
						rad_nx = lts_pkg::RADIX_HEX;
						len_nx = sat_inc(len_c);
						ph_nx = PH_SIGN;
					end else if (is_dec) begin
						rad_nx = {3'b000, item.ch[3:0]};
						rcnt_nx = 2'd1;
						len_nx = sat_inc(len_c);
						ph_nx = PH_RDIG;
					end else begin
						emit = 1'b1;
						ph_nx = PH_IDLE;
					end
				end
				PH_RDIG: begin
					if (item.eof) begin
						emit = 1'b1;
						ph_nx = PH_IDLE;
					end else if (rcnt_c < 2'd2 && is_dec) begin
						rad_nx = rad_mul[6:0];
						rcnt_nx = rcnt_c + 2'd1;
						len_nx = sat_inc(len_c);
					end else if (item.ch == lts_pkg::CH_LR || item.ch == lts_pkg::CH_UR) begin
						if (rad_c < lts_pkg::RADIX_MIN || rad_c > lts_pkg::RADIX_MAX) begin
							emit = 1'b1;
							ph_nx = PH_IDLE;
						end else begin
							len_nx = sat_inc(len_c);
							ph_nx = PH_SIGN;
						end
					end else begin
						emit = 1'b1;
						ph_nx = PH_IDLE;
					end
				end
				PH_SIGN: begin
					ph_nx = PH_DIGITS;
					if (!item.eof && (item.ch == lts_pkg::CH_PLUS ||
							item.ch == lts_pkg::CH_MINUS)) begin
						len_nx = sat_inc(len_c);
					end else begin
						do_digits = 1'b1;
					end
				end
				PH_DIGITS: begin
					do_digits = 1'b1;
				end
				PH_CMT: begin
					if (item.eof || item.ch == lts_pkg::CH_NEWLINE) begin
						emit = 1'b1;
						kind_o = lts_pkg::KIND_COMMENT;
						ph_nx = PH_IDLE;
					end else begin
						len_nx = sat_inc(len_c);
					end
				end
				default: begin
					ph_nx = PH_IDLE;
				end
			endcase

			// Digit run of a radix integer; the first non-digit decides.
			if (do_digits) begin
				if (!item.eof && dig.hit) begin
					seen_nx = 1'b1;
					if ({1'b0, dig.val} >= rad_c) begin
						dvalid_nx = 1'b0;
					end
					len_nx = sat_inc(len_c);
				end else begin
					emit = 1'b1;
					ph_nx = PH_IDLE;
					if (seen_c && dvalid_c) begin
						kind_o = lts_pkg::KIND_RADIX;
					end
				end
			end
		end
	end

	// Clamp the counters to the width of the result fields.
	if (COUNT_BITS > lts_pkg::OUT_COUNT_BITS) begin : g_wide
		assign skip16 = (|skip_nx[COUNT_BITS-1:lts_pkg::OUT_COUNT_BITS]) ?
			'1 : skip_nx[lts_pkg::OUT_COUNT_BITS-1:0];
		assign len16 = (|len_nx[COUNT_BITS-1:lts_pkg::OUT_COUNT_BITS]) ?
			'1 : len_nx[lts_pkg::OUT_COUNT_BITS-1:0];
	end else begin : g_narrow
		assign skip16 = lts_pkg::OUT_COUNT_BITS'(skip_nx);
		assign len16 = lts_pkg::OUT_COUNT_BITS'(len_nx);
	end

	// Result of a decided scan.
	always_comb begin
		res.kind = kind_o;
		res.skipped = skip16;
		res.length = (kind_o != lts_pkg::KIND_NONE) ? len16 : '0;
		res.took = (kind_o != lts_pkg::KIND_NONE) ? took_o : 1'b0;
	end

	// Scan state, advanced once per processed beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			mask_q <= '0;
			rad_q <= 7'd0;
			rcnt_q <= 2'd0;
			seen_q <= 1'b0;
			dvalid_q <= 1'b1;
			skip_q <= '0;
			len_q <= '0;
		end else if (step_en) begin
			ph_q <= ph_nx;
			mask_q <= mask_c;
			rad_q <= rad_nx;
			rcnt_q <= rcnt_nx;
			seen_q <= seen_nx;
			dvalid_q <= dvalid_nx;
			skip_q <= skip_nx;
			len_q <= len_nx;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/lisp_token_scanner.sv -----
// A result appears on out_valid once the beat that decides the scan is accepted into the
// input register and then processed into the result register, which it feeds directly.
// Throughput: one beat per cycle, stalls aside; the scan state advances in one step.
// A pending result that is not taken holds the input register, which backs up in_ready.
// Reset (arst_n low) clears the scan state to idle and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module lisp_token_scanner #(
	parameter int COUNT_BITS = lts_pkg::COUNT_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic start_scan,
	input wire logic [2:0] allowed_kinds,
	input wire logic [20:0] char_code,
	input wire logic at_end,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] token_kind,
	output logic [15:0] skipped_count,
	output logic [15:0] token_length,
	output logic took_current
);

	lts_pkg::item_t item_in;
	lts_pkg::item_t item_s1;
	lts_pkg::res_t res_c;
	lts_pkg::res_t res_q;
	logic valid_s1;
	logic advance;
	logic emit;
	logic out_valid_q;

	assign item_in.start = start_scan;
	assign item_in.mask = allowed_kinds;
	assign item_in.ch = char_code;
	assign item_in.eof = at_end;

	// The registered beat is processed when the result register can take a beat.
	assign advance = valid_s1 && (!out_valid_q || out_ready);

	lts_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.item(item_in),
		.advance(advance),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	lts_scan_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(advance),
		.item(item_s1),
		.emit(emit),
		.res(res_c)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign token_kind = res_q.kind;
	assign skipped_count = res_q.skipped;
	assign token_length = res_q.length;
	assign took_current = res_q.took;

endmodule

`default_nettype wire

// ----- dv/tb_lisp_token_scanner.sv -----
`timescale 1ns / 1ps

module tb_lisp_token_scanner;

	localparam logic [20:0] CH_RPAREN = 21'd41;
	localparam logic [20:0] CH_DOT = 21'd46;
	localparam int unsigned CODE_MAX = 1114111;
	localparam int FLUSH_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;

	// Scan phases of the expected-token model.
	typedef enum {
		SC_IDLE, SC_BLANK, SC_STR, SC_ESC, SC_HASH, SC_RDIG, SC_SIGN, SC_DIGITS, SC_CMT
	} scan_t;

	// Tracks the scan state, predicts each token report and checks the result beats.
	class token_checker;
		lts_pkg::res_t pending_tokens[$];
		int mismatches;
		int beats_seen;
		int kind_hits[4];
		scan_t phase;
		logic [2:0] kinds;
		int radix;
		int rdig_n;
		bit got_digit;
		bit digits_ok;
		logic [15:0] blank_n;
		logic [15:0] tok_n;

		function new();
			mismatches = 0;
			beats_seen = 0;
			kinds = 3'b000;
			foreach (kind_hits[i]) kind_hits[i] = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			phase = SC_IDLE;
			radix = 0;
			rdig_n = 0;
			got_digit = 0;
			digits_ok = 1;
			blank_n = '0;
			tok_n = '0;
		endfunction

		function logic [15:0] bump(logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function bit is_blank(logic [lts_pkg::CHAR_BITS-1:0] c);
			return c == lts_pkg::CH_SPACE || (c >= lts_pkg::CH_TAB && c <= lts_pkg::CH_CR);
		endfunction

		function bit is_dec(logic [lts_pkg::CHAR_BITS-1:0] c);
			return c >= lts_pkg::CH_0 && c <= lts_pkg::CH_9;
		endfunction

		// Radix named by the letter after the hash, or zero.
		function int letter_radix(logic [lts_pkg::CHAR_BITS-1:0] c);
			if (c == lts_pkg::CH_LB || c == lts_pkg::CH_UB) return lts_pkg::RADIX_BIN;
			if (c == lts_pkg::CH_LO || c == lts_pkg::CH_UO) return lts_pkg::RADIX_OCT;
			if (c == lts_pkg::CH_LX || c == lts_pkg::CH_UX) return lts_pkg::RADIX_HEX;
			return 0;
		endfunction

		// Worth of an alphanumeric digit, or -1.
		function int char_value(logic [lts_pkg::CHAR_BITS-1:0] c);
			if (is_dec(c)) return int'(c - lts_pkg::CH_0);
			if (c >= lts_pkg::CH_UA && c <= lts_pkg::CH_UZ) return int'(c - lts_pkg::CH_UA) + 10;
			if (c >= lts_pkg::CH_LA && c <= lts_pkg::CH_LZ) return int'(c - lts_pkg::CH_LA) + 10;
			return -1;
		endfunction

		// One beat of the digit run; returns 1 when the beat decides the scan.
		function bit digit_step(lts_pkg::item_t b, output lts_pkg::kind_t k);
			int v;
			k = lts_pkg::KIND_NONE;
			v = b.eof ? -1 : char_value(b.ch);
			if (v >= 0) begin
				got_digit = 1;
				if (v >= radix) digits_ok = 0;
				tok_n = bump(tok_n);
				return 0;
			end
			if (got_digit && digits_ok) k = lts_pkg::KIND_RADIX;
			return 1;
		endfunction

		// Advances the scan by one accepted beat and queues the report it decides.
		function void take_char(lts_pkg::item_t b);
			bit done;
			bit took;
			lts_pkg::kind_t k;
			lts_pkg::res_t r;
			done = 0;
			took = 0;
			k = lts_pkg::KIND_NONE;
			beats_seen++;
			if (b.start) begin
				clear_scan();
				kinds = b.mask;
				if (kinds == 3'b000) done = 1;
				else phase = SC_BLANK;
			end
			if (!done) begin
				case (phase)
				SC_BLANK: begin
					if (!b.eof && is_blank(b.ch)) begin
						blank_n = bump(blank_n);
					end else if (!b.eof && kinds[lts_pkg::MASK_STRING] &&
							b.ch == lts_pkg::CH_QUOTE) begin
						tok_n = bump(tok_n);
						phase = SC_STR;
					end else if (!b.eof && kinds[lts_pkg::MASK_RADIX] &&
							b.ch == lts_pkg::CH_HASH) begin
						tok_n = bump(tok_n);
						phase = SC_HASH;
					end else if (!b.eof && kinds[lts_pkg::MASK_COMMENT] &&
							b.ch == lts_pkg::CH_SEMI) begin
						tok_n = bump(tok_n);
						phase = SC_CMT;
					end else begin
						done = 1;
					end
				end
				SC_STR: begin
					if (b.eof) begin
						done = 1;
					end else begin
						tok_n = bump(tok_n);
						if (b.ch == lts_pkg::CH_QUOTE) begin
							done = 1;
							k = lts_pkg::KIND_STRING;
							took = 1;
						end else if (b.ch == lts_pkg::CH_BSLASH) begin
							phase = SC_ESC;
						end
					end
				end
				SC_ESC: begin
					if (b.eof) begin
						done = 1;
					end else begin
						tok_n = bump(tok_n);
						phase = SC_STR;
					end
				end
				SC_HASH: begin
					if (b.eof) begin
						done = 1;
					end else if (letter_radix(b.ch) != 0) begin
						radix = letter_radix(b.ch);
						tok_n = bump(tok_n);
						phase = SC_SIGN;
					end else if (is_dec(b.ch)) begin
						radix = int'(b.ch - lts_pkg::CH_0);
						rdig_n = 1;
						tok_n = bump(tok_n);
						phase = SC_RDIG;
					end else begin
						done = 1;
					end
				end
				SC_RDIG: begin
					if (b.eof) begin
						done = 1;
					end else if (rdig_n < 2 && is_dec(b.ch)) begin
						radix = radix * 10 + int'(b.ch - lts_pkg::CH_0);
						rdig_n++;
						tok_n = bump(tok_n);
					end else if (b.ch == lts_pkg::CH_LR || b.ch == lts_pkg::CH_UR) begin
						if (radix < lts_pkg::RADIX_MIN || radix > lts_pkg::RADIX_MAX) begin
							done = 1;
						end else begin
							tok_n = bump(tok_n);
							phase = SC_SIGN;
						end
					end else begin
						done = 1;
					end
				end
				SC_SIGN: begin
					if (!b.eof && (b.ch == lts_pkg::CH_PLUS || b.ch == lts_pkg::CH_MINUS)) begin
						tok_n = bump(tok_n);
						phase = SC_DIGITS;
					end else begin
						// No sign: this beat is already the first digit candidate.
						phase = SC_DIGITS;
						done = digit_step(b, k);
					end
				end
				SC_DIGITS: done = digit_step(b, k);
				SC_CMT: begin
					if (b.eof || b.ch == lts_pkg::CH_NEWLINE) begin
						done = 1;
						k = lts_pkg::KIND_COMMENT;
					end else begin
						tok_n = bump(tok_n);
					end
				end
				default: ;
				endcase
			end
			if (done) begin
				r.kind = k;
				r.skipped = blank_n;
				r.length = (k == lts_pkg::KIND_NONE) ? 16'd0 : tok_n;
				r.took = took;
				pending_tokens.push_back(r);
				phase = SC_IDLE;
			end
		endfunction

		function void flag(string what, longint want, longint got);
			mismatches++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
		endfunction

		// Compares one result beat with the oldest pending report.
		function void check_result(lts_pkg::res_t got);
			lts_pkg::res_t want;
			if (pending_tokens.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat, expected none, actual kind %0d length %0d",
					$time, got.kind, got.length);
				return;
			end
			want = pending_tokens.pop_front();
			kind_hits[int'(want.kind)]++;
			if (got.kind !== want.kind) flag("token_kind", want.kind, got.kind);
			if (got.skipped !== want.skipped) flag("skipped_count", want.skipped, got.skipped);
			if (got.length !== want.length) flag("token_length", want.length, got.length);
			if (got.took !== want.took) flag("took_current", want.took, got.took);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic start_scan = 1'b0;
	logic [2:0] allowed_kinds = 3'b000;
	logic [20:0] char_code = '0;
	logic at_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] token_kind;
	logic [15:0] skipped_count;
	logic [15:0] token_length;
	logic took_current;

	int src_idle_pct = 21;
	int sink_idle_pct = 61;
	int hold_asked = 0;
	int hold_seen = 0;
	token_checker board = new();

	lisp_token_scanner uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_scan(start_scan),
		.allowed_kinds(allowed_kinds),
		.char_code(char_code),
		.at_end(at_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.skipped_count(skipped_count),
		.token_length(token_length),
		.took_current(took_current)
	);

	always #4 clk = ~clk;

	// Watch both channels and hand each accepted beat to the checker.
	always @(posedge clk) begin
		lts_pkg::item_t b;
		lts_pkg::res_t r;
		if (arst_n && in_valid && in_ready) begin
			b.start = start_scan;
			b.mask = allowed_kinds;
			b.ch = char_code;
			b.eof = at_end;
			board.take_char(b);
		end
		if (arst_n && out_valid && out_ready) begin
			r.kind = lts_pkg::kind_t'(token_kind);
			r.skipped = skipped_count;
			r.length = token_length;
			r.took = took_current;
			board.check_result(r);
		end
	end

	// Result side: random stalls, plus a long hold-off whenever one is asked for.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_asked != hold_seen) begin
				hold_seen = hold_asked;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	function automatic lts_pkg::item_t mk(logic s, logic [2:0] m, logic [20:0] c, logic e);
		lts_pkg::item_t b;
		b.start = s;
		b.mask = m;
		b.ch = c;
		b.eof = e;
		return b;
	endfunction

	// Continuation beat; the mask is ignored there, so it is left random.
	function automatic lts_pkg::item_t beat(logic [20:0] c);
		return mk(1'b0, 3'($urandom_range(0, 7)), c, 1'b0);
	endfunction

	function automatic lts_pkg::item_t eof_beat();
		return mk(1'b0, 3'($urandom_range(0, 7)), 21'($urandom_range(0, CODE_MAX)), 1'b1);
	endfunction

	function automatic logic [20:0] blank_char();
		int r;
		r = $urandom_range(8, 13);
		return (r == 8) ? lts_pkg::CH_SPACE : 21'(r);
	endfunction

	// Mostly printable text, some control codes and some wide code points.
	function automatic logic [20:0] text_char();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 21'($urandom_range(0, 31));
		if (r == 1) return 21'($urandom_range(128, CODE_MAX));
		return 21'($urandom_range(32, 126));
	endfunction

	function automatic logic [20:0] alnum_of(int v);
		if (v < 10) return lts_pkg::CH_0 + 21'(v);
		return ($urandom_range(0, 1) ? lts_pkg::CH_LA : lts_pkg::CH_UA) + 21'(v - 10);
	endfunction

	// Builds one scan: leading blanks, then a mostly well-formed token.
	function automatic void build_scan(ref lts_pkg::item_t q[$]);
		int n;
		int radix;
		int lim;
		int r;
		q.delete();
		repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0)
			q.push_back(beat(blank_char()));
		case ($urandom_range(0, 9))
		0, 1, 2: begin
			q.push_back(beat(lts_pkg::CH_QUOTE));
			repeat ($urandom_range(0, 6)) begin
				if ($urandom_range(0, 5) == 0) q.push_back(beat(lts_pkg::CH_BSLASH));
				q.push_back(beat(text_char()));
			end
			q.push_back(($urandom_range(0, 9) == 0) ? eof_beat() : beat(lts_pkg::CH_QUOTE));
		end
		3, 4, 5: begin
			q.push_back(beat(lts_pkg::CH_HASH));
			case ($urandom_range(0, 5))
			0: begin
				radix = 2;
				q.push_back(beat($urandom_range(0, 1) ? lts_pkg::CH_LB : lts_pkg::CH_UB));
			end
			1: begin
				radix = 8;
				q.push_back(beat($urandom_range(0, 1) ? lts_pkg::CH_LO : lts_pkg::CH_UO));
			end
			2: begin
				radix = 16;
				q.push_back(beat($urandom_range(0, 1) ? lts_pkg::CH_LX : lts_pkg::CH_UX));
			end
			3: begin
				radix = $urandom_range(0, 9);
				q.push_back(beat(lts_pkg::CH_0 + 21'(radix)));
				q.push_back(beat($urandom_range(0, 1) ? lts_pkg::CH_LR : lts_pkg::CH_UR));
			end
			4: begin
				radix = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 99) :
					$urandom_range(2, 36);
				q.push_back(beat(lts_pkg::CH_0 + 21'(radix / 10)));
				q.push_back(beat(lts_pkg::CH_0 + 21'(radix % 10)));
				// A third radix digit makes the prefix malformed.
				if ($urandom_range(0, 7) == 0)
					q.push_back(beat(lts_pkg::CH_0 + 21'($urandom_range(0, 9))));
				q.push_back(beat($urandom_range(0, 1) ? lts_pkg::CH_LR : lts_pkg::CH_UR));
			end
			default: begin
				radix = 36;
				q.push_back(beat(text_char()));
			end
			endcase
			r = $urandom_range(0, 3);
			if (r == 0) q.push_back(beat(lts_pkg::CH_PLUS));
			if (r == 1) q.push_back(beat(lts_pkg::CH_MINUS));
			lim = (radix >= 2 && radix <= 36) ? radix : 36;
			repeat ($urandom_range(0, 5))
				q.push_back(beat(alnum_of(($urandom_range(0, 9) == 0) ?
					$urandom_range(0, 35) : $urandom_range(0, lim - 1))));
			case ($urandom_range(0, 3))
			0: q.push_back(eof_beat());
			1: q.push_back(beat(lts_pkg::CH_SPACE));
			2: q.push_back(beat(CH_RPAREN));
			default: q.push_back(beat(CH_DOT));
			endcase
		end
		6, 7: begin
			q.push_back(beat(lts_pkg::CH_SEMI));
			repeat ($urandom_range(0, 6)) q.push_back(beat(text_char()));
			q.push_back(($urandom_range(0, 4) == 0) ? eof_beat() : beat(lts_pkg::CH_NEWLINE));
		end
		default: begin
			q.push_back(($urandom_range(0, 3) == 0) ? eof_beat() :
				beat(21'($urandom_range(0, CODE_MAX))));
		end
		endcase
		q[0].start = 1'b1;
		q[0].mask = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'b111;
		// Cut some scans short so the next start lands mid-token.
		if ($urandom_range(0, 11) == 0 && q.size() > 1) begin
			n = $urandom_range(1, q.size() - 1);
			repeat (n) void'(q.pop_back());
		end
		// A stray beat with no start, usually while idle.
		if ($urandom_range(0, 7) == 0) q.push_back(beat(text_char()));
	endfunction

	// Offer one beat, with random idle cycles first, and hold it until accepted.
	task automatic send_beat(input lts_pkg::item_t b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_scan <= b.start;
		allowed_kinds <= b.mask;
		char_code <= b.ch;
		at_end <= b.eof;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic run_random(input int quota);
		lts_pkg::item_t scan_q[$];
		int sent;
		sent = 0;
		while (sent < quota) begin
			build_scan(scan_q);
			foreach (scan_q[i]) send_beat(scan_q[i]);
			sent += scan_q.size();
		end
	endtask

	// Stop sending until every predicted token has been reported.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending_tokens.size() != 0) @(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	initial begin
		#8_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty mask decides at once without looking at the character.
		send_beat(mk(1'b1, 3'b000, lts_pkg::CH_LX, 1'b0));
		// String with an escaped quote, after a tab.
		send_beat(mk(1'b1, 3'b111, lts_pkg::CH_TAB, 1'b0));
		send_beat(beat(lts_pkg::CH_QUOTE));
		send_beat(beat(lts_pkg::CH_BSLASH));
		send_beat(beat(lts_pkg::CH_QUOTE));
		send_beat(beat(lts_pkg::CH_QUOTE));
		// Explicit radix 12 with a sign, ended by end of input.
		send_beat(mk(1'b1, 3'b010, lts_pkg::CH_HASH, 1'b0));
		send_beat(beat(lts_pkg::CH_0 + 21'd1));
		send_beat(beat(lts_pkg::CH_0 + 21'd2));
		send_beat(beat(lts_pkg::CH_LR));
		send_beat(beat(lts_pkg::CH_MINUS));
		send_beat(beat(lts_pkg::CH_UB));
		send_beat(eof_beat());
		// Comment closed by end of input.
		send_beat(mk(1'b1, 3'b100, lts_pkg::CH_SEMI, 1'b0));
		send_beat(eof_beat());
		// Radix 37 is rejected on the r.
		send_beat(mk(1'b1, 3'b111, lts_pkg::CH_HASH, 1'b0));
		send_beat(beat(lts_pkg::CH_0 + 21'd3));
		send_beat(beat(lts_pkg::CH_0 + 21'd7));
		send_beat(beat(lts_pkg::CH_UR));
		// Restart in the middle of a string, then end of input right away.
		send_beat(mk(1'b1, 3'b001, lts_pkg::CH_QUOTE, 1'b0));
		send_beat(beat(lts_pkg::CH_LA));
		send_beat(mk(1'b1, 3'b111, 21'd0, 1'b1));
		// Ignored while idle, at the top code point.
		send_beat(beat(21'(CODE_MAX)));
		// Semicolon when comments are not allowed.
		send_beat(mk(1'b1, 3'b011, lts_pkg::CH_SEMI, 1'b0));
		run_random(130);
		drain();

		// Sender mostly idle; the receiver also blocks for a long stretch.
		src_idle_pct = 61;
		sink_idle_pct = 21;
		hold_asked <= hold_asked + 1;
		run_random(150);
		drain();

		// Full rate on both sides.
		src_idle_pct = 0;
		sink_idle_pct = 0;
		run_random(150);
		drain();

		$display("Scanned %0d beats: directed corner cases, then three stall mixes.",
			board.beats_seen);
		$display("Tokens checked: %0d none, %0d string, %0d radix, %0d comment.",
			board.kind_hits[lts_pkg::KIND_NONE], board.kind_hits[lts_pkg::KIND_STRING],
			board.kind_hits[lts_pkg::KIND_RADIX], board.kind_hits[lts_pkg::KIND_COMMENT]);
		if (board.mismatches == 0 && board.pending_tokens.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- lisp_token_scanner.f -----
rtl/core/lts_pkg.sv
rtl/core/lts_in_stage.sv
rtl/core/lts_scan_core.sv
rtl/core/lisp_token_scanner.sv
dv/tb_lisp_token_scanner.sv
